// ===== hdl/sia_pkg.sv =====
`default_nettype none

package sia_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Control that the sequencer drives into every digit cell of the row.
  typedef struct packed {
    logic clear;   // start a new number: all digits to zero
    logic dabble;  // one add-3-and-shift step of the binary to BCD conversion
    logic move;    // pass digits one place toward the most significant end
  } sia_cell_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/sia_in_if.sv =====
`default_nettype none

interface sia_in_if
  import sia_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/sia_out_if.sv =====
`default_nettype none

interface sia_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii.sv =====
// Channel    Role     Beat carries
// in_chan    sink     value (VALUE_BITS, signed)
// out_chan   source   character (8), last (1)
//
// One number is accepted, converted bit by bit, most significant bit first,
// through the row of BCD digit cells, then read out of the row digit by digit:
// leading zero cells are dropped, and a negative number gets a minus sign first.
// Reset (rst_n, synchronous) returns the sequencer to idle and empties the
// output register. A stall on out_chan holds the read-out; in_chan is ready
// again once the final character sits in the output register.
`default_nettype none

module signed_int_to_decimal_ascii
  import sia_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sia_in_if.sink     in_chan,
  sia_out_if.source  out_chan
);

  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int REM_W  = $clog2(DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic                  started_r, started_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  accept;
  logic                  slot_free;
  logic [VALUE_BITS-1:0] in_bits;
  sia_cell_ctl_t         ctl;
  logic [3:0]            top_digit;
  logic [DIGITS:0]       carry;
  logic [3:0]            digit [DIGITS+1];

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign in_bits       = in_chan.value;
  assign slot_free     = !out_valid_r || out_chan.ready;

  // Cell 0 holds the least significant digit; the binary magnitude enters
  // there most significant bit first.
  assign carry[0] = mag_r[VALUE_BITS-1];
  assign digit[0] = 4'd0;
  assign top_digit = digit[DIGITS];

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    sia_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .bit_in    (carry[i]),
      .digit_in  (digit[i]),
      .carry_out (carry[i+1]),
      .digit_out (digit[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctl.clear   = 1'b1;
          neg_nxt     = in_bits[VALUE_BITS-1];
          // The most negative value negates to itself, which read unsigned
          // is exactly its magnitude.
          mag_nxt     = in_bits[VALUE_BITS-1] ? (~in_bits + 1'b1) : in_bits;
          cnt_nxt     = '0;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.dabble = 1'b1;
        mag_nxt    = {mag_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
          rem_nxt     = REM_W'(DIGITS);
          started_nxt = 1'b0;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (neg_r) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CHAR_MINUS;
            out_last_nxt  = 1'b0;
            neg_nxt       = 1'b0;
          end
        end else if (!started_r && top_digit == 4'd0 && rem_r != REM_W'(1)) begin
          ctl.move = 1'b1;
          rem_nxt  = rem_r - 1'b1;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {4'd0, top_digit};
          out_last_nxt  = (rem_r == REM_W'(1));
          ctl.move      = 1'b1;
          rem_nxt       = rem_r - 1'b1;
          started_nxt   = 1'b1;
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      started_r   <= started_nxt;
    end
    mag_r      <= mag_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.character = out_char_r;
  assign out_chan.last      = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/sia_cell.sv =====
`default_nettype none

module sia_cell
  import sia_pkg::*;
(
  input  wire logic          clk,
  input  wire sia_cell_ctl_t ctl,
  input  wire logic          bit_in,
  input  wire logic [3:0]    digit_in,
  output logic               carry_out,
  output logic [3:0]         digit_out
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  // A digit of five or more would reach ten or more after the shift, so it is
  // corrected by three first and its top bit carries into the next cell.
  always_comb begin
    adj = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
    carry_out = adj[3];
    digit_nxt = digit_r;
    if (ctl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctl.dabble) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctl.move) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit_out = digit_r;

endmodule

`default_nettype wire

// ===== hdl/sia_checker.sv =====
`default_nettype none

module sia_checker
  import sia_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_character,
  input wire logic       out_last
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS) ||
                  (out_character >= CHAR_ZERO && out_character <= CHAR_ZERO + 8'd9))
    else $error("character is neither a sign nor a digit");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == CHAR_MINUS |-> !out_last)
    else $error("minus sign marked as final character");

  // A number occupies the converter, so no second one is taken right away.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while converting");

endmodule

bind signed_int_to_decimal_ascii sia_checker u_sia_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_character (out_chan.character),
  .out_last      (out_chan.last)
);

`default_nettype wire
